// ===== design/ttrr_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and step functions for the triangle ratio pipeline.
package ttrr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIV_STEPS  = 32;
   localparam int SQRT_STEPS = 33;
   localparam int NUM_BITS   = 33 + FRAC_BITS;
   localparam int NSTG       = 2 * DIV_STEPS + SQRT_STEPS + 9;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BEHIND = 2'd1,
      ST_DEGEN  = 2'd2
   } stat_type;

   typedef struct packed {
      logic signed [31:0] p0_x;
      logic signed [31:0] p0_y;
      logic signed [31:0] p0_z;
      logic signed [31:0] p1_x;
      logic signed [31:0] p1_y;
      logic signed [31:0] p1_z;
      logic signed [31:0] p2_x;
      logic signed [31:0] p2_y;
      logic signed [31:0] p2_z;
   } req_type;

   typedef struct packed {
      logic [31:0] ratio;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      stat_type    status;
      logic [31:0] spread;
   } ctl_type;

   typedef struct packed {
      logic [5:0][31:0] mag;
      logic [5:0]       neg;
      logic [2:0][31:0] z;
      logic [31:0]      mn;
      ctl_type          ctl;
   } front_type;

   typedef struct packed {
      logic [5:0][63:0] acc;
      logic [5:0]       neg;
      logic [2:0][31:0] z;
      ctl_type          ctl;
   } prj_type;

   typedef struct packed {
      logic [5:0][32:0] p;
      ctl_type          ctl;
   } pos_type;

   typedef struct packed {
      logic [5:0][32:0] dm;
      ctl_type          ctl;
   } dif_type;

   typedef struct packed {
      logic [5:0][63:0] sq;
      ctl_type          ctl;
   } sqr_type;

   typedef struct packed {
      logic [2:0][64:0] s;
      ctl_type          ctl;
   } sum_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [32:0] root;
      logic [65:0] n;
      ctl_type     ctl;
   } sqrt_type;

   typedef struct packed {
      logic [63:0] acc;
      logic        sat;
      ctl_type     ctl;
   } quo_type;

   // one restoring division step: remainder high, dividend/quotient low
   function automatic logic [63:0] div_step(input logic [63:0] acc,
                                            input logic [31:0] dvs);
      logic [32:0] t;
      logic [32:0] dif;
      logic [63:0] res;
      t   = {acc[63:32], acc[31]};
      dif = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         res = {dif[31:0], acc[30:0], 1'b1};
      end else begin
         res = {t[31:0], acc[30:0], 1'b0};
      end
      return res;
   endfunction

   // one bit of the digit-by-digit square root
   function automatic sqrt_type sqrt_step(input sqrt_type cur);
      sqrt_type    nxt;
      logic [35:0] t;
      logic [35:0] trial;
      nxt   = cur;
      t     = {cur.rem[33:0], cur.n[65:64]};
      trial = {1'b0, cur.root, 2'b01};
      if (t >= trial) begin
         nxt.rem  = t - trial;
         nxt.root = {cur.root[31:0], 1'b1};
      end else begin
         nxt.rem  = t;
         nxt.root = {cur.root[31:0], 1'b0};
      end
      nxt.n = {cur.n[63:0], 2'b00};
      return nxt;
   endfunction

endpackage

// ===== design/triangle_tangential_radial_ratio.sv =====
`timescale 1ns / 1ps
// Top level: triangle tangential-to-radial ratio pipeline.
// Takes one triangle per cycle while no result is held and returns its ratio.
// The pipeline holds two 32-stage restoring dividers (projection and final
// ratio) and a 33-stage square root, each retiring one bit per stage. A held
// result stalls the whole pipeline, which then stalls the input.
module triangle_tangential_radial_ratio (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ttrr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttrr_pkg::rsp_type rsp_payload
);

   logic                          adv;
   logic [ttrr_pkg::NSTG-1:0]     vld_ff;
   ttrr_pkg::front_type           fr_ff, fr_in;
   ttrr_pkg::prj_type             pj_ff [0:ttrr_pkg::DIV_STEPS];
   ttrr_pkg::prj_type             pj_in;
   ttrr_pkg::prj_type             pj_st_in [1:ttrr_pkg::DIV_STEPS];
   ttrr_pkg::pos_type             ps_ff, ps_in;
   ttrr_pkg::dif_type             df_ff, df_in;
   ttrr_pkg::sqr_type             sq_ff, sq_in;
   ttrr_pkg::sum_type             sm_ff, sm_in;
   ttrr_pkg::sqrt_type            sr_ff [0:ttrr_pkg::SQRT_STEPS];
   ttrr_pkg::sqrt_type            sr_in;
   ttrr_pkg::quo_type             qt_ff [0:ttrr_pkg::DIV_STEPS];
   ttrr_pkg::quo_type             qt_in;
   ttrr_pkg::quo_type             qt_st_in [1:ttrr_pkg::DIV_STEPS];
   ttrr_pkg::rsp_type             out_ff, out_in;

   assign adv         = !(vld_ff[ttrr_pkg::NSTG-1] && rsp_stall);
   assign req_stall   = !adv;
   assign rsp_valid   = vld_ff[ttrr_pkg::NSTG-1];
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ttrr_pkg::NSTG-2:0], req_valid};
      end
   end

   // front: depth range, checks, magnitudes
   always_comb begin
      logic signed [31:0] mn;
      logic signed [31:0] mx;
      logic signed [31:0] v [0:5];
      logic signed [31:0] z [0:2];
      v[0] = req_payload.p0_x; v[1] = req_payload.p0_y;
      v[2] = req_payload.p1_x; v[3] = req_payload.p1_y;
      v[4] = req_payload.p2_x; v[5] = req_payload.p2_y;
      z[0] = req_payload.p0_z; z[1] = req_payload.p1_z; z[2] = req_payload.p2_z;
      mn = z[0];
      mx = z[0];
      for (int i = 1; i < 3; i++) begin
         if (z[i] < mn) mn = z[i];
         if (z[i] > mx) mx = z[i];
      end
      fr_in = '0;
      for (int i = 0; i < 6; i++) begin
         fr_in.neg[i] = v[i][31];
         fr_in.mag[i] = v[i][31] ? 32'(-v[i]) : 32'(v[i]);
      end
      for (int i = 0; i < 3; i++) begin
         fr_in.z[i] = 32'(z[i]);
      end
      fr_in.mn         = 32'(mn);
      fr_in.ctl.spread = 32'(mx - mn);
      if (mn < 0) begin
         fr_in.ctl.status = ttrr_pkg::ST_BEHIND;
      end else if (mn == 0 || mx == mn) begin
         fr_in.ctl.status = ttrr_pkg::ST_DEGEN;
      end else begin
         fr_in.ctl.status = ttrr_pkg::ST_OK;
      end
   end

   // products |v| * minz
   always_comb begin
      pj_in     = '0;
      pj_in.neg = fr_ff.neg;
      pj_in.z   = fr_ff.z;
      pj_in.ctl = fr_ff.ctl;
      for (int i = 0; i < 6; i++) begin
         pj_in.acc[i] = fr_ff.mag[i] * fr_ff.mn;
      end
   end

   // divider steps for projection and ratio
   always_comb begin
      for (int k = 0; k < ttrr_pkg::DIV_STEPS; k++) begin
         pj_st_in[k + 1] = pj_ff[k];
         for (int i = 0; i < 6; i++) begin
            pj_st_in[k + 1].acc[i] = ttrr_pkg::div_step(pj_ff[k].acc[i],
                                                        pj_ff[k].z[i / 2]);
         end
         qt_st_in[k + 1]     = qt_ff[k];
         qt_st_in[k + 1].acc = ttrr_pkg::div_step(qt_ff[k].acc, qt_ff[k].ctl.spread);
      end
   end

   // signed projected coordinates
   always_comb begin
      ps_in     = '0;
      ps_in.ctl = pj_ff[ttrr_pkg::DIV_STEPS].ctl;
      for (int i = 0; i < 6; i++) begin
         ps_in.p[i] = pj_ff[ttrr_pkg::DIV_STEPS].neg[i]
                      ? 33'(-{1'b0, pj_ff[ttrr_pkg::DIV_STEPS].acc[i][31:0]})
                      : {1'b0, pj_ff[ttrr_pkg::DIV_STEPS].acc[i][31:0]};
      end
   end

   // edge deltas: pairs 0-1, 1-2, 0-2, each x then y
   always_comb begin
      logic signed [33:0] d;
      df_in     = '0;
      df_in.ctl = ps_ff.ctl;
      for (int k = 0; k < 2; k++) begin
         d = 34'($signed(ps_ff.p[k])) - 34'($signed(ps_ff.p[2 + k]));
         df_in.dm[k] = d[33] ? 33'(-d) : d[32:0];
         d = 34'($signed(ps_ff.p[2 + k])) - 34'($signed(ps_ff.p[4 + k]));
         df_in.dm[2 + k] = d[33] ? 33'(-d) : d[32:0];
         d = 34'($signed(ps_ff.p[k])) - 34'($signed(ps_ff.p[4 + k]));
         df_in.dm[4 + k] = d[33] ? 33'(-d) : d[32:0];
      end
   end

   always_comb begin
      logic [65:0] pr;
      sq_in     = '0;
      sq_in.ctl = df_ff.ctl;
      for (int i = 0; i < 6; i++) begin
         pr          = df_ff.dm[i] * df_ff.dm[i];
         sq_in.sq[i] = pr[63:0];
      end
   end

   always_comb begin
      sm_in     = '0;
      sm_in.ctl = sq_ff.ctl;
      for (int k = 0; k < 3; k++) begin
         sm_in.s[k] = {1'b0, sq_ff.sq[2 * k]} + {1'b0, sq_ff.sq[2 * k + 1]};
      end
   end

   // longest edge, square root set-up
   always_comb begin
      logic [64:0] best;
      best = sm_ff.s[0];
      if (best <= sm_ff.s[1]) best = sm_ff.s[1];
      if (best <= sm_ff.s[2]) best = sm_ff.s[2];
      sr_in      = '0;
      sr_in.n    = {1'b0, best};
      sr_in.ctl  = sm_ff.ctl;
   end

   // ratio division set-up and saturation test
   always_comb begin
      logic [ttrr_pkg::NUM_BITS-1:0] num;
      num       = {sr_ff[ttrr_pkg::SQRT_STEPS].root, {ttrr_pkg::FRAC_BITS{1'b0}}};
      qt_in     = '0;
      qt_in.acc = 64'(num);
      qt_in.sat = 64'(num) >= {sr_ff[ttrr_pkg::SQRT_STEPS].ctl.spread, 32'd0};
      qt_in.ctl = sr_ff[ttrr_pkg::SQRT_STEPS].ctl;
   end

   always_comb begin
      out_in = '0;
      case (qt_ff[ttrr_pkg::DIV_STEPS].ctl.status)
         ttrr_pkg::ST_OK: begin
            out_in.status = ttrr_pkg::ST_OK;
            out_in.ratio  = qt_ff[ttrr_pkg::DIV_STEPS].sat
                            ? 32'hFFFF_FFFF : qt_ff[ttrr_pkg::DIV_STEPS].acc[31:0];
         end
         ttrr_pkg::ST_BEHIND: begin
            out_in.status = ttrr_pkg::ST_BEHIND;
            out_in.ratio  = 32'd0;
         end
         default: begin
            out_in.status = ttrr_pkg::ST_DEGEN;
            out_in.ratio  = 32'hFFFF_FFFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff    <= fr_in;
         pj_ff[0] <= pj_in;
         for (int k = 0; k < ttrr_pkg::DIV_STEPS; k++) begin
            pj_ff[k + 1] <= pj_st_in[k + 1];
         end
         ps_ff    <= ps_in;
         df_ff    <= df_in;
         sq_ff    <= sq_in;
         sm_ff    <= sm_in;
         sr_ff[0] <= sr_in;
         for (int k = 0; k < ttrr_pkg::SQRT_STEPS; k++) begin
            sr_ff[k + 1] <= ttrr_pkg::sqrt_step(sr_ff[k]);
         end
         qt_ff[0] <= qt_in;
         for (int k = 0; k < ttrr_pkg::DIV_STEPS; k++) begin
            qt_ff[k + 1] <= qt_st_in[k + 1];
         end
         out_ff   <= out_in;
      end
   end

endmodule

// ===== design/ttrr_check.sv =====
`timescale 1ns / 1ps
// Port checker for the triangle ratio pipeline, bound to the top level.
module ttrr_check (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ttrr_pkg::rsp_type rsp_payload
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled item changed");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled without a held item");

   a_behind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ttrr_pkg::ST_BEHIND
      |-> rsp_payload.ratio == 32'd0)
      else $error("behind-camera item with non-zero ratio");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ttrr_pkg::ST_DEGEN
      |-> rsp_payload.ratio == 32'hFFFF_FFFF)
      else $error("degenerate item not saturated");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status != 2'd3)
      else $error("unused status code");

endmodule

bind triangle_tangential_radial_ratio ttrr_check u_ttrr_check (.*);
